// File: hdl/mhs_pkg.sv
// ----------------------------------------------------------------------------
// Motor homing sequencer package
// Shared types, codes and widths for the homing front end, queue and sequencer.
// ----------------------------------------------------------------------------
package mhs_pkg;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 112;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  // wait timer spans minus the largest tick up to the largest delay
  localparam int unsigned WaitW    = 25;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;

  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_DOWN_SLOW  = 3'd1;
  localparam logic [2:0] CMD_BRAKE      = 3'd2;
  localparam logic [2:0] CMD_UP_FAST    = 3'd3;
  localparam logic [2:0] CMD_UP_SLOW    = 3'd4;
  localparam logic [2:0] CMD_GOTO_LOWER = 3'd5;

  localparam logic [1:0] END_NONE   = 2'd0;
  localparam logic [1:0] END_BOTTOM = 2'd1;
  localparam logic [1:0] END_TOP    = 2'd2;
  localparam logic [1:0] END_BOTH   = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_STOP_SPEED   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_TIME  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_DELAY  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT_MARGIN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SAFE_BACKOFF = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_LEN_TOL      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_EXP_LEN      = 3'd6;

  typedef struct packed {
    logic [14:0]        stop_speed;
    logic [23:0]        settle_time_us;
    logic [23:0]        start_delay_us;
    logic [15:0]        limit_margin;
    logic [15:0]        safe_backoff;
    logic [15:0]        length_tolerance;
    logic signed [31:0] expected_length;
  } cfg_t;

  // classified request as held in the queue
  typedef struct packed {
    logic        is_tick;
    logic        is_start;
    logic        is_abort;
    logic        stalled;
    logic        at_target;
    logic [15:0] dt_us;
    logic [31:0] position;
    logic [31:0] pos_add_margin;
    logic [31:0] pos_sub_margin;
    logic [31:0] pos_add_backoff;
  } item_t;

endpackage

// File: hdl/motor_homing_sequencer.sv
// ----------------------------------------------------------------------------
// Motor homing sequencer
// Finds both end stops of a roller by stall detection and reports the limits.
// ----------------------------------------------------------------------------
// an accepted request passes the queue, then the registered result stage, before its result is valid
// throughput: one request per cycle unless the output stalls, set by the combinational sequencer step
// a two-entry queue and a registered result stage decouple input from output
// reset: queue and result stage empty, sequencer idle, registers at defaults
module motor_homing_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mhs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mhs_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // dt_us[15:0], position[47:16], speed[63:48], at_target[64], zero fill
  input  logic [mhs_pkg::InDataW-1:0]       s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // motor_cmd[2:0], end_select[4:3], encoder_reset[5], clear_limits[6],
  // limits_valid[7], lower_limit[39:8], upper_limit[71:40],
  // measured_length[103:72], length_match[104], busy_res[105],
  // finished[106], zero fill
  output logic [mhs_pkg::OutDataW-1:0]      m_axis_tdata
);
  import mhs_pkg::*;

  cfg_t  cfg_q;
  item_t front_item;
  item_t queue_item;
  logic  push;
  logic  q_ready;
  logic  q_valid;
  logic  pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_speed       <= 15'd26;
      cfg_q.settle_time_us   <= 24'd600000;
      cfg_q.start_delay_us   <= 24'd500000;
      cfg_q.limit_margin     <= 16'd512;
      cfg_q.safe_backoff     <= 16'd3072;
      cfg_q.length_tolerance <= 16'd1024;
      cfg_q.expected_length  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STOP_SPEED:   cfg_q.stop_speed       <= cfg_data_i[14:0];
        CFG_SETTLE_TIME:  cfg_q.settle_time_us   <= cfg_data_i[23:0];
        CFG_START_DELAY:  cfg_q.start_delay_us   <= cfg_data_i[23:0];
        CFG_LIMIT_MARGIN: cfg_q.limit_margin     <= cfg_data_i[15:0];
        CFG_SAFE_BACKOFF: cfg_q.safe_backoff     <= cfg_data_i[15:0];
        CFG_LEN_TOL:      cfg_q.length_tolerance <= cfg_data_i[15:0];
        CFG_EXP_LEN:      cfg_q.expected_length  <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  mhs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_i         (cfg_q),
    .q_ready_i     (q_ready),
    .push_o        (push),
    .item_o        (front_item)
  );

  mhs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (queue_item)
  );

  mhs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .item_i        (queue_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: hdl/mhs_front.sv
// ----------------------------------------------------------------------------
// Homing front end
// Accepts requests, decodes the opcode, flags a stall and forms the position
// sums the sequencer needs, then hands the request to the queue.
// ----------------------------------------------------------------------------
module mhs_front (
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // dt_us[15:0], position[47:16], speed[63:48], at_target[64], zero fill
  input  logic [mhs_pkg::InDataW-1:0]           s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]                            s_axis_tuser,
  input  mhs_pkg::cfg_t                         cfg_i,
  input  logic                                  q_ready_i,
  output logic                                  push_o,
  output mhs_pkg::item_t                        item_o
);
  import mhs_pkg::*;

  logic signed [15:0] speed;
  logic [16:0]        speed_mag;
  logic [31:0]        position;

  assign speed    = s_axis_tdata[63:48];
  assign position = s_axis_tdata[47:16];

  // magnitude needs one extra bit for the most negative speed
  assign speed_mag = speed[15] ? (17'd0 - {speed[15], speed}) : {1'b0, speed};

  assign s_axis_tready = q_ready_i;
  assign push_o        = s_axis_tvalid && q_ready_i;

  always_comb begin
    item_o.is_tick         = (s_axis_tuser == OP_TICK);
    item_o.is_start        = (s_axis_tuser == OP_START);
    item_o.is_abort        = (s_axis_tuser == OP_ABORT);
    item_o.stalled         = (speed_mag < {2'b00, cfg_i.stop_speed});
    item_o.at_target       = s_axis_tdata[64];
    item_o.dt_us           = s_axis_tdata[15:0];
    item_o.position        = position;
    item_o.pos_add_margin  = position + {16'd0, cfg_i.limit_margin};
    item_o.pos_sub_margin  = position - {16'd0, cfg_i.limit_margin};
    item_o.pos_add_backoff = position + {16'd0, cfg_i.safe_backoff};
  end

endmodule

// File: hdl/mhs_queue.sv
// ----------------------------------------------------------------------------
// Homing request queue
// Short first-in first-out buffer between the front end and the sequencer.
// ----------------------------------------------------------------------------
module mhs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mhs_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mhs_pkg::item_t item_o
);
  import mhs_pkg::*;

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  assign ready_o = (count_q != QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue holds more than its depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill count lost a push");

endmodule

// File: hdl/mhs_back.sv
// ----------------------------------------------------------------------------
// Homing sequencer
// Carries out queued requests one per cycle unless the output stalls:
// wait timer, homing phases, limit latching and length check, into a registered result stage.
// ----------------------------------------------------------------------------
module mhs_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mhs_pkg::cfg_t                   cfg_i,
  input  logic                            q_valid_i,
  input  mhs_pkg::item_t                  item_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // motor_cmd[2:0], end_select[4:3], encoder_reset[5], clear_limits[6],
  // limits_valid[7], lower_limit[39:8], upper_limit[71:40],
  // measured_length[103:72], length_match[104], busy_res[105],
  // finished[106], zero fill
  output logic [mhs_pkg::OutDataW-1:0]    m_axis_tdata
);
  import mhs_pkg::*;

  typedef enum logic [2:0] {
    PH_MARK        = 3'd0,
    PH_SEEK_LOW    = 3'd1,
    PH_SETTLE_LOW  = 3'd2,
    PH_RISE        = 3'd3,
    PH_SETTLE_HIGH = 3'd4,
    PH_RETURN      = 3'd5
  } phase_e;

  phase_e             phase_q, phase_d;
  logic               active_q, active_d;
  logic [WaitW-1:0]   wait_q, wait_d;
  logic [31:0]        safe_q, safe_d;
  logic [31:0]        lower_q, lower_d;
  logic [31:0]        upper_q, upper_d;
  logic [31:0]        length_q, length_d;
  logic               match_q, match_d;
  logic               out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [WaitW-1:0]   wait_dec;
  logic               expired;
  logic [32:0]        len_diff;
  logic [32:0]        len_mag;
  logic               len_ok;
  logic [2:0]         cmd;
  logic [1:0]         endsel;
  logic               enc_rst, clr, lim_valid, fin;

  assign pop_o = q_valid_i && (!out_valid_q || m_axis_tready);

  // timer only counts down while not yet negative
  assign wait_dec = wait_q[WaitW-1] ? wait_q : wait_q - WaitW'(item_i.dt_us);
  assign expired  = wait_dec[WaitW-1];

  assign len_diff = {cfg_i.expected_length[31], cfg_i.expected_length}
                  - {length_q[31], length_q};
  assign len_mag  = len_diff[32] ? (33'd0 - len_diff) : len_diff;
  assign len_ok   = len_mag < {17'd0, cfg_i.length_tolerance};

  always_comb begin
    phase_d   = phase_q;
    active_d  = active_q;
    wait_d    = wait_q;
    safe_d    = safe_q;
    lower_d   = lower_q;
    upper_d   = upper_q;
    length_d  = length_q;
    match_d   = match_q;
    cmd       = CMD_NONE;
    endsel    = END_NONE;
    enc_rst   = 1'b0;
    clr       = 1'b0;
    lim_valid = 1'b0;
    fin       = 1'b0;
    priority if (item_i.is_start) begin
      if (!active_q) begin
        phase_d  = PH_MARK;
        wait_d   = '1;
        safe_d   = '1;
        match_d  = 1'b0;
        active_d = 1'b1;
      end
    end else if (item_i.is_abort) begin
      active_d = 1'b0;
    end else if (item_i.is_tick && active_q) begin
      wait_d = wait_dec;
      unique case (phase_q)
        PH_MARK: begin
          enc_rst = 1'b1;
          safe_d  = item_i.position;
          endsel  = END_BOTTOM;
          cmd     = CMD_DOWN_SLOW;
          clr     = 1'b1;
          wait_d  = WaitW'(cfg_i.start_delay_us);
          phase_d = PH_SEEK_LOW;
        end
        PH_SEEK_LOW: begin
          if (item_i.stalled && expired) begin
            endsel  = END_BOTH;
            cmd     = CMD_BRAKE;
            wait_d  = WaitW'(cfg_i.settle_time_us);
            phase_d = PH_SETTLE_LOW;
          end
        end
        PH_SETTLE_LOW: begin
          if (expired) begin
            // fast zone ends the backoff short of where homing began
            safe_d  = safe_q - item_i.pos_add_backoff;
            enc_rst = 1'b1;
            lower_d = item_i.pos_add_margin;
            endsel  = END_TOP;
            cmd     = CMD_UP_FAST;
            wait_d  = WaitW'(cfg_i.start_delay_us);
            phase_d = PH_RISE;
          end
        end
        PH_RISE: begin
          if ($signed(item_i.position) > $signed(safe_q)) begin
            cmd = CMD_UP_SLOW;
          end
          // a stall overrides slowing down
          if (item_i.stalled && expired) begin
            endsel  = END_BOTH;
            cmd     = CMD_BRAKE;
            wait_d  = WaitW'(cfg_i.settle_time_us);
            phase_d = PH_SETTLE_HIGH;
          end
        end
        PH_SETTLE_HIGH: begin
          if (expired) begin
            upper_d  = item_i.pos_sub_margin;
            length_d = item_i.pos_sub_margin - lower_q;
            cmd      = CMD_GOTO_LOWER;
            phase_d  = PH_RETURN;
          end
        end
        PH_RETURN: begin
          if (item_i.at_target) begin
            match_d   = len_ok;
            lim_valid = 1'b1;
            fin       = 1'b1;
            active_d  = 1'b0;
            phase_d   = PH_MARK;
            safe_d    = '1;
            wait_d    = '1;
          end
        end
        default: begin
          active_d = 1'b0;
          phase_d  = PH_MARK;
          safe_d   = '1;
          wait_d   = '1;
        end
      endcase
    end else begin
      // idle tick or unused opcode leaves the state alone
    end
  end

  always_comb begin
    out_data_d = {5'd0, fin, active_d, match_d, length_d, upper_d, lower_d,
                  lim_valid, clr, enc_rst, endsel, cmd};
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MARK;
      active_q    <= 1'b0;
      wait_q      <= '1;
      safe_q      <= '1;
      lower_q     <= '0;
      upper_q     <= '0;
      length_q    <= '0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q    <= phase_d;
        active_q   <= active_d;
        wait_q     <= wait_d;
        safe_q     <= safe_d;
        lower_q    <= lower_d;
        upper_q    <= upper_d;
        length_q   <= length_d;
        match_q    <= match_d;
        out_data_q <= out_data_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.is_start && !active_q |=> active_q && phase_q == PH_MARK)
    else $error("start while idle did not arm the sequence");

  a_abort_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.is_abort |=> !active_q)
    else $error("abort left the sequence active");

  a_finish_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && fin |=> out_data_q[7] && !out_data_q[105] && !active_q)
    else $error("finished result without limits or still busy");

endmodule
